[rtl/nbps_pkg.sv]
`default_nettype none
package nbps_pkg;

   typedef enum logic [1:0] {
      OP_ADD_EXACT  = 2'd0,
      OP_ADD_PREFIX = 2'd1,
      OP_CHECK      = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_CLEAN    = 2'd0,
      VERDICT_BLACK    = 2'd1,
      VERDICT_PREFIX   = 2'd2,
      VERDICT_REPORTED = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   // table being scanned
   typedef enum logic [1:0] {
      PH_REPORTED = 2'd0,
      PH_EXACT    = 2'd1,
      PH_PREFIX   = 2'd2
   } phase_type;

endpackage
`default_nettype wire

[rtl/nbps_if.sv]
`default_nettype none
interface nbps_req_if #(parameter int DW = 64, parameter int CW = 5);
   logic          valid;
   logic          ready;
   logic [1:0]    operation;
   logic [DW-1:0] digits;
   logic [CW-1:0] digit_count;
   logic [7:0]    label_id;
   modport source (output valid, operation, digits, digit_count, label_id, input ready);
   modport sink   (input valid, operation, digits, digit_count, label_id, output ready);
endinterface

interface nbps_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;
   logic [7:0] hit_label;
   logic       table_full;
   modport source (output valid, verdict, hit_label, table_full, input ready);
   modport sink   (input valid, verdict, hit_label, table_full, output ready);
endinterface
`default_nettype wire

[rtl/nbps_table.sv]
`default_nettype none
// Table store; one entry per scan cycle is read out (registered).
module nbps_table #(
   parameter int DEPTH = 16,
   parameter int DW    = 64,
   parameter int CW    = 5,
   parameter int LW    = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DW-1:0]            wr_digits,
   input  wire logic [CW-1:0]            wr_length,
   input  wire logic [LW-1:0]            wr_label,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [DW-1:0]            rd_digits,
   output      logic [CW-1:0]            rd_length,
   output      logic [LW-1:0]            rd_label
);
   logic [DW+CW+LW-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_digits, wr_length, wr_label};
      end
      {rd_digits, rd_length, rd_label} <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/nbps_cell.sv]
`default_nettype none
// One compare cell: digit nibble k against stored entry, hands running match to next cell.
module nbps_cell #(
   parameter int K = 0
) (
   input  wire logic [3:0] key_nib,
   input  wire logic [3:0] ent_nib,
   input  wire logic [4:0] plen,
   input  wire logic       eq_in,
   output      logic       eq_out
);
   // Past the prefix length nibbles do not matter.
   assign eq_out = eq_in && ((5'(K) >= plen) || (key_nib == ent_nib));
endmodule
`default_nettype wire

[rtl/number_blacklist_prefix_screen.sv]
`default_nettype none
// Number blacklist / prefix screen.
// req: one transaction per operation (add exact, add prefix, check, clear).
// rsp: one transaction per request with verdict, hit_label, table_full.
// A request scans the reported set, exact table and prefix table one entry
// per cycle through a registered read port, comparing digits in a row of
// nibble cells. Each scanned table is read through its used entries; the
// last read is compared once its registered data arrives, then the scan
// closes. Adds scan only their own table; a check scans reported, then
// exact, then prefix, and skips the remaining tables after a reported or
// exact hit; clear scans no table and empties only the reported set.
// One request at a time; req.ready is high only while idle, so the next
// request is accepted in the cycle after the result is taken.
// Reset (synchronous, active high) empties all tables by zeroing use counts.
// The result sits in an output register; if the receiver stalls, it holds
// and the next request is accepted only once the result has been taken.
module number_blacklist_prefix_screen #(
   parameter int MAX_DIGITS       = 16,
   parameter int EXACT_ENTRIES    = 16,
   parameter int PREFIX_ENTRIES   = 16,
   parameter int REPORTED_ENTRIES = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   nbps_req_if.sink  req,
   nbps_rsp_if.source rsp
);
   localparam int DW = 4 * MAX_DIGITS;
   localparam int EA = $clog2(EXACT_ENTRIES);
   localparam int PA = $clog2(PREFIX_ENTRIES);
   localparam int RA = $clog2(REPORTED_ENTRIES);
   localparam int EU = $clog2(EXACT_ENTRIES + 1);
   localparam int PU = $clog2(PREFIX_ENTRIES + 1);
   localparam int RU = $clog2(REPORTED_ENTRIES + 1);
   localparam int IW = $clog2(REPORTED_ENTRIES + EXACT_ENTRIES + PREFIX_ENTRIES + 2);

   nbps_pkg::state_type state_ff, state_in;
   nbps_pkg::op_type    op_ff, op_in;
   logic [DW-1:0] key_ff, key_in;
   logic [4:0]    len_ff, len_in;
   logic [7:0]    lab_ff, lab_in;
   logic [EU-1:0] eused_ff, eused_in;
   logic [PU-1:0] pused_ff, pused_in;
   logic [RU-1:0] rused_ff, rused_in;
   nbps_pkg::phase_type ph_ff, ph_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          vld_ff, vld_in;       // a read issued last cycle
   logic [IW-1:0] vidx_ff, vidx_in;
   logic          rhit_ff, rhit_in, ehit_ff, ehit_in, found_ff, found_in;
   logic [PA-1:0] fidx_ff, fidx_in;
   logic [4:0]    best_ff, best_in;
   logic [7:0]    blab_ff, blab_in;
   logic [1:0]    vd_ff, vd_in;
   logic [7:0]    hl_ff, hl_in;
   logic          tf_ff, tf_in;

   // digit masking and count clamp
   logic [4:0]    n_clamp;
   logic [DW-1:0] d_mask;
   always_comb begin
      n_clamp = (req.digit_count > 5'(MAX_DIGITS)) ? 5'(MAX_DIGITS) : req.digit_count;
      for (int k = 0; k < MAX_DIGITS; k++) begin
         d_mask[4*k +: 4] = (5'(k) < n_clamp) ? req.digits[4*k +: 4] : 4'd0;
      end
   end

   // tables
   logic          e_we, p_we, r_we;
   logic [EA-1:0] e_wa, e_ra;
   logic [PA-1:0] p_wa, p_ra;
   logic [RA-1:0] r_wa, r_ra;
   logic [DW-1:0] e_rd, p_rd, r_rd;
   logic [4:0]    e_rl, p_rl, r_rl;
   logic [7:0]    e_lb, p_lb, r_lb, p_wl;
   logic [DW-1:0] p_wd;
   logic [4:0]    p_wlen;

   nbps_table #(.DEPTH(EXACT_ENTRIES), .DW(DW), .CW(5), .LW(8)) u_exact (
      .clock, .wr_en(e_we), .wr_addr(e_wa), .wr_digits(key_ff), .wr_length(len_ff),
      .wr_label(8'd0), .rd_addr(e_ra), .rd_digits(e_rd), .rd_length(e_rl), .rd_label(e_lb));
   nbps_table #(.DEPTH(PREFIX_ENTRIES), .DW(DW), .CW(5), .LW(8)) u_prefix (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_digits(p_wd), .wr_length(p_wlen),
      .wr_label(p_wl), .rd_addr(p_ra), .rd_digits(p_rd), .rd_length(p_rl), .rd_label(p_lb));
   nbps_table #(.DEPTH(REPORTED_ENTRIES), .DW(DW), .CW(5), .LW(8)) u_rep (
      .clock, .wr_en(r_we), .wr_addr(r_wa), .wr_digits(key_ff), .wr_length(len_ff),
      .wr_label(8'd0), .rd_addr(r_ra), .rd_digits(r_rd), .rd_length(r_rl), .rd_label(r_lb));

   // compare row: full-length match (exact/reported) and prefix match
   logic [DW-1:0] cmp_d;
   logic [4:0]    cmp_l;
   logic [4:0]    cmp_plen;
   logic [MAX_DIGITS:0] chain;
   always_comb begin
      unique case (ph_ff)
         nbps_pkg::PH_REPORTED: begin cmp_d = r_rd; cmp_l = r_rl; end
         nbps_pkg::PH_EXACT:    begin cmp_d = e_rd; cmp_l = e_rl; end
         default:               begin cmp_d = p_rd; cmp_l = p_rl; end
      endcase
      // exact compare uses all nibbles (both masked); prefix uses its length
      cmp_plen = (ph_ff == nbps_pkg::PH_PREFIX) ? cmp_l : 5'(MAX_DIGITS);
   end
   assign chain[0] = 1'b1;
   for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
      nbps_cell #(.K(k)) u_cell (
         .key_nib(key_ff[4*k +: 4]), .ent_nib(cmp_d[4*k +: 4]),
         .plen(cmp_plen), .eq_in(chain[k]), .eq_out(chain[k+1]));
   end
   logic full_eq, pre_eq;
   assign full_eq = chain[MAX_DIGITS] && (cmp_l == len_ff);
   assign pre_eq  = chain[MAX_DIGITS] && (cmp_l != 5'd0) && (cmp_l <= len_ff);

   assign e_ra = EA'(idx_ff);
   assign p_ra = PA'(idx_ff);
   assign r_ra = RA'(idx_ff);

   // phase limit
   logic [IW-1:0] lim;
   always_comb begin
      unique case (ph_ff)
         nbps_pkg::PH_REPORTED: lim = IW'(rused_ff);
         nbps_pkg::PH_EXACT:    lim = IW'(eused_ff);
         default:               lim = IW'(pused_ff);
      endcase
   end

   logic do_in, do_out;
   assign req.ready = (state_ff == nbps_pkg::ST_IDLE);
   assign do_in  = req.valid && req.ready;
   assign do_out = rsp.valid && rsp.ready;

   // next-state logic
   logic scan_end;
   assign scan_end = (idx_ff >= lim) && !vld_ff;
   logic last_phase;
   always_comb begin
      unique case (op_ff)
         nbps_pkg::OP_CHECK: last_phase = (ph_ff == nbps_pkg::PH_PREFIX);
         default:            last_phase = 1'b1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nbps_pkg::ST_IDLE: if (do_in) state_in = nbps_pkg::ST_SCAN;
         nbps_pkg::ST_SCAN: begin
            if (op_ff == nbps_pkg::OP_CLEAR) state_in = nbps_pkg::ST_DONE;
            else if (scan_end && last_phase) state_in = nbps_pkg::ST_DONE;
            else if (op_ff == nbps_pkg::OP_CHECK && scan_end && (rhit_ff || ehit_ff))
               state_in = nbps_pkg::ST_DONE;
         end
         nbps_pkg::ST_DONE: if (do_out) state_in = nbps_pkg::ST_IDLE;
         default: state_in = nbps_pkg::ST_IDLE;
      endcase
   end

   // datapath / outputs
   always_comb begin
      op_in = op_ff; key_in = key_ff; len_in = len_ff; lab_in = lab_ff;
      eused_in = eused_ff; pused_in = pused_ff; rused_in = rused_ff;
      ph_in = ph_ff; idx_in = idx_ff; vld_in = 1'b0; vidx_in = idx_ff;
      rhit_in = rhit_ff; ehit_in = ehit_ff; found_in = found_ff; fidx_in = fidx_ff;
      best_in = best_ff; blab_in = blab_ff;
      vd_in = vd_ff; hl_in = hl_ff; tf_in = tf_ff;
      e_we = 1'b0; p_we = 1'b0; r_we = 1'b0;
      e_wa = EA'(eused_ff); p_wa = PA'(pused_ff); r_wa = RA'(rused_ff);
      p_wd = key_ff; p_wlen = len_ff; p_wl = lab_ff;
      if (state_ff == nbps_pkg::ST_IDLE && do_in) begin
         op_in = nbps_pkg::op_type'(req.operation);
         key_in = d_mask; len_in = n_clamp; lab_in = req.label_id;
         idx_in = '0; rhit_in = 1'b0; ehit_in = 1'b0; found_in = 1'b0;
         best_in = 5'(MAX_DIGITS) + 5'd1; blab_in = 8'd0;
         unique case (nbps_pkg::op_type'(req.operation))
            nbps_pkg::OP_ADD_EXACT:  ph_in = nbps_pkg::PH_EXACT;
            nbps_pkg::OP_ADD_PREFIX: ph_in = nbps_pkg::PH_PREFIX;
            default:                 ph_in = nbps_pkg::PH_REPORTED;
         endcase
      end else if (state_ff == nbps_pkg::ST_SCAN) begin
         // evaluate the entry read last cycle
         if (vld_ff) begin
            unique case (ph_ff)
               nbps_pkg::PH_REPORTED: if (full_eq) rhit_in = 1'b1;
               nbps_pkg::PH_EXACT:    if (full_eq) ehit_in = 1'b1;
               default: begin
                  if (op_ff == nbps_pkg::OP_ADD_PREFIX) begin
                     if (full_eq && !found_in) begin
                        found_in = 1'b1; fidx_in = PA'(vidx_ff);
                     end
                  end else if (pre_eq && (p_rl < best_ff)) begin
                     best_in = p_rl; blab_in = p_lb;
                  end
               end
            endcase
         end
         if (idx_ff < lim) begin
            vld_in = 1'b1; vidx_in = idx_ff; idx_in = idx_ff + IW'(1);
         end
         if (op_ff == nbps_pkg::OP_CLEAR) begin
            rused_in = '0; vd_in = nbps_pkg::VERDICT_CLEAN; hl_in = 8'd0; tf_in = 1'b0;
         end else if (scan_end) begin
            vd_in = nbps_pkg::VERDICT_CLEAN; hl_in = 8'd0; tf_in = 1'b0;
            unique case (op_ff)
               nbps_pkg::OP_ADD_EXACT: begin
                  if (!ehit_ff) begin
                     if (eused_ff < EU'(EXACT_ENTRIES)) begin
                        e_we = 1'b1; eused_in = eused_ff + EU'(1);
                     end else tf_in = 1'b1;
                  end
               end
               nbps_pkg::OP_ADD_PREFIX: begin
                  if (len_ff != 5'd0) begin
                     if (found_ff) begin
                        p_we = 1'b1; p_wa = fidx_ff;
                     end else if (pused_ff < PU'(PREFIX_ENTRIES)) begin
                        p_we = 1'b1; pused_in = pused_ff + PU'(1);
                     end else tf_in = 1'b1;
                  end
               end
               default: begin
                  if (rhit_ff) vd_in = nbps_pkg::VERDICT_REPORTED;
                  else if (ehit_ff) vd_in = nbps_pkg::VERDICT_BLACK;
                  else if (last_phase && best_ff <= 5'(MAX_DIGITS)) begin
                     vd_in = nbps_pkg::VERDICT_PREFIX; hl_in = blab_ff;
                  end
                  if (!rhit_ff && (ehit_ff || last_phase)) begin
                     if (ehit_ff || best_ff <= 5'(MAX_DIGITS)) begin
                        if (rused_ff < RU'(REPORTED_ENTRIES)) begin
                           r_we = 1'b1; rused_in = rused_ff + RU'(1);
                        end else tf_in = 1'b1;
                     end
                  end
                  if (!rhit_ff && !ehit_ff && !last_phase) begin
                     ph_in = (ph_ff == nbps_pkg::PH_REPORTED) ? nbps_pkg::PH_EXACT
                                                              : nbps_pkg::PH_PREFIX;
                     idx_in = '0;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nbps_pkg::ST_IDLE;
         eused_ff <= '0; pused_ff <= '0; rused_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         eused_ff <= eused_in; pused_ff <= pused_in; rused_ff <= rused_in;
         vld_ff <= vld_in;
      end
      op_ff <= op_in; key_ff <= key_in; len_ff <= len_in; lab_ff <= lab_in;
      ph_ff <= ph_in; idx_ff <= idx_in; vidx_ff <= vidx_in;
      rhit_ff <= rhit_in; ehit_ff <= ehit_in; found_ff <= found_in; fidx_ff <= fidx_in;
      best_ff <= best_in; blab_ff <= blab_in;
      vd_ff <= vd_in; hl_ff <= hl_in; tf_ff <= tf_in;
   end

   assign rsp.valid      = (state_ff == nbps_pkg::ST_DONE);
   assign rsp.verdict    = vd_ff;
   assign rsp.hit_label  = hl_ff;
   assign rsp.table_full = tf_ff | (|{e_lb, r_lb} & 1'b0);
endmodule
`default_nettype wire
